// File: rtl/kpsd_pkg.sv
package kpsd_pkg;

    localparam int LINE_W    = 32;
    localparam int CNT_W     = 8;
    localparam int KEY_W     = 9;
    localparam int KNUM_W    = 6;
    localparam int IDX_W     = 6;
    localparam int DRV_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int SINGLE_CAP = 32;

    localparam logic [CNT_W-1:0] LATCHED    = 8'hFF;
    localparam logic [CNT_W-1:0] JITTER_CAP = 8'd254;
    localparam logic [DRV_W-1:0] NO_DRIVE   = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_KEYS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER      = 3'd4;

    typedef struct packed {
        logic start;
        logic read_first;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic last_key;
        logic event_hit;
        logic pend_valid;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic              event_valid;
        logic [KNUM_W-1:0] key_number;
        logic              is_press;
        logic [DRV_W-1:0]  row_drive;
        logic              last_result;
    } t_result;

endpackage

// File: rtl/kpsd_in_if.sv
interface kpsd_in_if;
    logic                          valid;
    logic                          ready;
    logic [kpsd_pkg::LINE_W-1:0]   line_levels;

    modport source (output valid, output line_levels, input ready);
    modport sink   (input valid, input line_levels, output ready);
endinterface

// File: rtl/kpsd_out_if.sv
interface kpsd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          event_valid;
    logic [kpsd_pkg::KNUM_W-1:0]   key_number;
    logic                          is_press;
    logic [kpsd_pkg::DRV_W-1:0]    row_drive;
    logic                          last_result;

    modport source (output valid, output event_valid, output key_number, output is_press,
                    output row_drive, output last_result, input ready);
    modport sink   (input valid, input event_valid, input key_number, input is_press,
                    input row_drive, input last_result, output ready);
endinterface

// File: rtl/kpsd_ctrl.sv
module kpsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kpsd_pkg::t_sts i_sts,
    output kpsd_pkg::t_cmd o_cmd
);
    import kpsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_rdy, n_rdy;
    logic   w_stall;

    assign w_stall = i_sts.event_hit && i_sts.pend_valid && !i_sts.out_free;

    always_comb begin
        n_state = r_state;
        n_rdy   = r_rdy;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && r_rdy) begin
                    o_cmd.start = 1'b1;
                    n_rdy       = 1'b0;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                if (i_sts.done) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.read_first = 1'b1;
                    n_state          = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!w_stall) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last_key) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_rdy       = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_rdy   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rdy   <= 1'b1;
        end else begin
            r_state <= n_state;
            r_rdy   <= n_rdy;
        end
    end

    assign o_in_ready = r_rdy;

endmodule

// File: rtl/kpsd_datapath.sv
module kpsd_datapath #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    parameter int MAX_KEYS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kpsd_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic [kpsd_pkg::LINE_W-1:0]         i_lines,
    input  kpsd_pkg::t_cmd                      i_cmd,
    output kpsd_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    output kpsd_pkg::t_result                   o_out,
    input  logic                                i_out_ready
);
    import kpsd_pkg::*;

    localparam int ADDR_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int COL_CAP = (MAX_COLS > 32) ? 32 : MAX_COLS;

    logic             r_mode;
    logic [3:0]       r_rows_cfg;
    logic [3:0]       r_cols_cfg;
    logic [5:0]       r_keys_cfg;
    logic [CNT_W-1:0] r_jit;
    logic [2:0]       r_cur_row;

    logic [LINE_W-1:0] r_lines;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_limit;
    logic [KEY_W-1:0]  r_key;
    logic [DRV_W-1:0]  r_drive;

    logic              r_pend_valid;
    logic [KNUM_W-1:0] r_pend_key;
    logic              r_pend_press;

    logic              r_out_valid;
    t_result           r_out;

    logic [CNT_W-1:0]  r_mem [MAX_KEYS];
    logic              r_vld [MAX_KEYS];
    logic [CNT_W-1:0]  r_rd_data;
    logic              r_rd_vld;

    logic [3:0]        w_rows;
    logic [2:0]        w_row;
    logic [3:0]        w_nxt4;
    logic [2:0]        w_nxt;
    logic [IDX_W-1:0]  w_cols;
    logic [IDX_W-1:0]  w_keys;
    logic [KEY_W-1:0]  w_base;
    logic [DRV_W-1:0]  w_drive;
    logic [KEY_W-1:0]  w_key_inc;
    logic [IDX_W-1:0]  w_idx_inc;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_rd_en;
    logic [CNT_W-1:0]  w_jt;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_cnt_new;
    logic              w_line;
    logic              w_act;
    logic              w_press;
    logic              w_release;
    logic              w_out_free;
    logic              w_push;
    t_result           w_push_val;

    always_comb begin
        if (r_rows_cfg == 4'd0) begin
            w_rows = 4'd1;
        end else if (r_rows_cfg > 4'(MAX_ROWS)) begin
            w_rows = 4'(MAX_ROWS);
        end else begin
            w_rows = r_rows_cfg;
        end
        w_row  = ({1'b0, r_cur_row} >= w_rows) ? 3'd0 : r_cur_row;
        w_nxt4 = {1'b0, w_row} + 4'd1;
        w_nxt  = (w_nxt4 >= w_rows) ? 3'd0 : w_nxt4[2:0];
        if (r_cols_cfg == 4'd0) begin
            w_cols = 6'd1;
        end else if ({2'b00, r_cols_cfg} > 6'(COL_CAP)) begin
            w_cols = 6'(COL_CAP);
        end else begin
            w_cols = {2'b00, r_cols_cfg};
        end
        if (r_keys_cfg == 6'd0) begin
            w_keys = 6'd1;
        end else if (r_keys_cfg > 6'(SINGLE_CAP)) begin
            w_keys = 6'(SINGLE_CAP);
        end else begin
            w_keys = r_keys_cfg;
        end
        w_base  = KEY_W'(w_row) * KEY_W'(w_cols);
        w_drive = ~(8'd1 << w_nxt);
    end

    assign w_key_inc = r_key + KEY_W'(1);
    assign w_idx_inc = r_idx + IDX_W'(1);
    assign w_rd_en   = i_cmd.read_first || i_cmd.step;
    assign w_rd_addr = i_cmd.step ? w_key_inc[ADDR_W-1:0] : r_key[ADDR_W-1:0];
    assign w_wr_addr = r_key[ADDR_W-1:0];

    assign w_jt   = (r_jit == LATCHED) ? JITTER_CAP : r_jit;
    assign w_cnt  = r_rd_vld ? r_rd_data : '0;
    assign w_line = r_lines[r_idx[4:0]];
    assign w_act  = r_mode ? w_line : !w_line;

    assign w_press   = w_act && (w_cnt >= w_jt) && (w_cnt != LATCHED);
    assign w_release = !w_act && (w_cnt == LATCHED);

    always_comb begin
        if (w_act && (w_cnt < w_jt)) begin
            w_cnt_new = w_cnt + CNT_W'(1);
        end else if (w_press) begin
            w_cnt_new = LATCHED;
        end else if (w_release) begin
            w_cnt_new = '0;
        end else begin
            w_cnt_new = w_cnt;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_push     = 1'b0;
        w_push_val = '0;
        w_push_val.row_drive = r_drive;
        if (i_cmd.step && (w_press || w_release) && r_pend_valid) begin
            w_push                 = 1'b1;
            w_push_val.event_valid = 1'b1;
            w_push_val.key_number  = r_pend_key;
            w_push_val.is_press    = r_pend_press;
        end else if (i_cmd.flush) begin
            w_push                  = 1'b1;
            w_push_val.event_valid  = r_pend_valid;
            w_push_val.key_number   = r_pend_valid ? r_pend_key : '0;
            w_push_val.is_press     = r_pend_valid && r_pend_press;
            w_push_val.last_result  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_rows_cfg   <= 4'd4;
            r_cols_cfg   <= 4'd4;
            r_keys_cfg   <= 6'd8;
            r_jit        <= 8'd5;
            r_cur_row    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < MAX_KEYS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCAN_MODE:   r_mode     <= i_cfg_data[0];
                    CFG_ROW_COUNT:   r_rows_cfg <= i_cfg_data[3:0];
                    CFG_COL_COUNT:   r_cols_cfg <= i_cfg_data[3:0];
                    CFG_SINGLE_KEYS: r_keys_cfg <= i_cfg_data[5:0];
                    CFG_JITTER:      r_jit      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start && !r_mode) begin
                r_cur_row <= w_nxt;
            end
            if (i_cmd.step) begin
                r_vld[w_wr_addr] <= 1'b1;
                if (w_press || w_release) begin
                    r_pend_valid <= 1'b1;
                end
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lines <= i_lines;
            r_idx   <= '0;
            r_key   <= r_mode ? '0 : w_base;
            r_limit <= r_mode ? w_keys : w_cols;
            r_drive <= r_mode ? NO_DRIVE : w_drive;
        end else if (i_cmd.step) begin
            r_idx <= w_idx_inc;
            r_key <= w_key_inc;
        end
        if (i_cmd.step && (w_press || w_release)) begin
            r_pend_key   <= r_key[KNUM_W-1:0];
            r_pend_press <= w_press;
        end
        if (i_cmd.step) begin
            r_mem[w_wr_addr] <= w_cnt_new;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
        end
        if (w_push) begin
            r_out <= w_push_val;
        end
    end

    assign o_sts.done       = (r_idx == r_limit) || (r_key >= KEY_W'(MAX_KEYS));
    assign o_sts.last_key   = (w_idx_inc == r_limit) || (w_key_inc >= KEY_W'(MAX_KEYS));
    assign o_sts.event_hit  = w_press || w_release;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_flush_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_out_valid && r_out.last_result))
        else $error("final result not presented after flush");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> ((r_idx < r_limit) && (r_key < KEY_W'(MAX_KEYS))))
        else $error("key step outside scan range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_out_valid) |-> i_out_ready)
        else $error("output register overwritten before it was taken");

endmodule

// File: rtl/keypad_scan_debounce.sv
// Channel   Direction  Payload                                              Beat
// i_samp    in         line_levels[31:0]                                    one sense sample
// o_evt     out        event_valid, key_number, is_press, row_drive, last   one result
// i_cfg_*   in         i_cfg_idx selects the register, i_cfg_data[7:0]      write when i_cfg_we
//
// One sample walks the counter memory over the keys scanned (columns in matrix mode, keys
// in single mode, at most 32), one key a cycle unless a stalled output holds the scan.
// Reset is synchronous; counters read as zero until first written after reset.
// A new sample is taken only once all results of the previous one are in the output register.
// A stalled output holds the scan at the next event and at the final result.
module keypad_scan_debounce #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    parameter int MAX_KEYS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kpsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kpsd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    kpsd_in_if.sink                        i_samp,
    kpsd_out_if.source                     o_evt
);
    import kpsd_pkg::*;

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_res;
    logic    w_res_valid;
    logic    w_in_ready;

    kpsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_samp.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kpsd_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_lines     (i_samp.line_levels),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (w_res_valid),
        .o_out       (w_res),
        .i_out_ready (o_evt.ready)
    );

    assign i_samp.ready      = w_in_ready;
    assign o_evt.valid       = w_res_valid;
    assign o_evt.event_valid = w_res.event_valid;
    assign o_evt.key_number  = w_res.key_number;
    assign o_evt.is_press    = w_res.is_press;
    assign o_evt.row_drive   = w_res.row_drive;
    assign o_evt.last_result = w_res.last_result;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import kpsd_pkg::*;

    localparam int KEY_SLOTS    = 64;
    localparam int ROW_CAP      = 8;
    localparam int COL_CAP      = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 32;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle_mode;
    typedef enum bit {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_data;
        logic [LINE_W-1:0]    levels;
        logic                 typed;
        t_result              want;
    } t_scan_row;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;

    kpsd_in_if  samp_if ();
    kpsd_out_if evt_if ();

    keypad_scan_debounce u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_samp     (samp_if),
        .o_evt      (evt_if)
    );

    logic [CNT_W-1:0] key_counts [KEY_SLOTS];
    logic [2:0]       scan_row;
    logic             single_mode;
    logic [3:0]       row_setting;
    logic [3:0]       col_setting;
    logic [5:0]       key_setting;
    logic [7:0]       jitter_setting;

    t_result   step_res [SINGLE_CAP];
    int        step_n;
    t_result   expected_q [$];
    t_scan_row directed_rows [$];
    logic [63:0] held_keys;

    t_idle_mode idle_mode;
    int errors;
    int hold_reqs;
    int hold_done;
    int hold_left;
    int quiet_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int eff_count(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int row_now();
        int r;
        r = scan_row;
        if (r >= eff_count(row_setting, ROW_CAP)) r = 0;
        return r;
    endfunction

    function automatic int src_idle_pct();
        if (idle_mode == IDLE_SRC) return 46;
        if (idle_mode == IDLE_BOTH) return 29;
        return 0;
    endfunction

    function automatic int snk_stall_pct();
        if (idle_mode == IDLE_SNK) return 46;
        if (idle_mode == IDLE_BOTH) return 29;
        return 0;
    endfunction

    function automatic t_result res(input logic ev, input logic [KNUM_W-1:0] key,
                                    input logic press, input logic [DRV_W-1:0] drv);
        t_result r;
        r = {ev, key, press, drv, 1'b1};
        return r;
    endfunction

    function automatic t_scan_row sample_row(input logic [LINE_W-1:0] lv);
        t_scan_row s;
        s = '0;
        s.kind = ROW_SAMPLE;
        s.levels = lv;
        return s;
    endfunction

    function automatic t_scan_row typed_row(input logic [LINE_W-1:0] lv, input t_result w);
        t_scan_row s;
        s = sample_row(lv);
        s.typed = 1'b1;
        s.want = w;
        return s;
    endfunction

    function automatic t_scan_row write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DAT_W-1:0] data);
        t_scan_row s;
        s = '0;
        s.kind = ROW_WRITE;
        s.reg_idx = idx;
        s.reg_data = data;
        return s;
    endfunction

    task automatic add_event(input logic ev, input logic [KNUM_W-1:0] key,
                             input logic press, input logic [DRV_W-1:0] drv);
        step_res[step_n] = {ev, key, press, drv, 1'b0};
        step_n++;
    endtask

    task automatic debounce_key(input int key, input logic act, input logic [DRV_W-1:0] drv);
        logic [CNT_W-1:0] jt;
        logic [CNT_W-1:0] c;
        jt = (jitter_setting == LATCHED) ? JITTER_CAP : jitter_setting;
        c = key_counts[key];
        if (act) begin
            if (c < jt) begin
                key_counts[key] = c + 1'b1;
            end else if (c != LATCHED) begin
                key_counts[key] = LATCHED;
                add_event(1'b1, key[KNUM_W-1:0], 1'b1, drv);
            end
        end else if (c == LATCHED) begin
            key_counts[key] = '0;
            add_event(1'b1, key[KNUM_W-1:0], 1'b0, drv);
        end
    endtask

    task automatic scan_predict(input logic [LINE_W-1:0] lv);
        int rows;
        int cols;
        int r;
        int nxt;
        int i;
        logic [DRV_W-1:0] drv;
        step_n = 0;
        if (!single_mode) begin
            rows = eff_count(row_setting, ROW_CAP);
            cols = eff_count(col_setting, COL_CAP);
            r = row_now();
            nxt = r + 1;
            if (nxt >= rows) nxt = 0;
            scan_row = nxt[2:0];
            drv = ~(8'd1 << nxt);
            for (i = 0; i < cols; i++) begin
                if (r * cols + i < KEY_SLOTS) debounce_key(r * cols + i, ~lv[i], drv);
            end
        end else begin
            drv = NO_DRIVE;
            for (i = 0; i < eff_count(key_setting, SINGLE_CAP); i++) begin
                debounce_key(i, lv[i], drv);
            end
        end
        if (step_n == 0) add_event(1'b0, '0, 1'b0, drv);
        step_res[step_n-1].last_result = 1'b1;
    endtask

    function automatic logic [LINE_W-1:0] next_levels();
        logic [LINE_W-1:0] v;
        int r;
        int n;
        int i;
        int idx;
        idx = $urandom_range(0, 63);
        if ($urandom_range(0, 5) == 0) held_keys[idx] = ~held_keys[idx];
        if ($urandom_range(0, 39) == 0) held_keys = {$urandom, $urandom} & {$urandom, $urandom};
        v = $urandom;
        if ($urandom_range(0, 9) == 0) return v;
        if (!single_mode) begin
            n = eff_count(col_setting, COL_CAP);
            r = row_now();
            for (i = 0; i < n; i++) v[i] = ~held_keys[r * n + i];
        end else begin
            n = eff_count(key_setting, SINGLE_CAP);
            for (i = 0; i < n; i++) v[i] = held_keys[i];
        end
        idx = $urandom_range(0, 7);
        if ($urandom_range(0, 11) == 0) v[idx] = ~v[idx];
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SCAN_MODE:   single_mode = data[0];
            CFG_ROW_COUNT:   row_setting = data[3:0];
            CFG_COL_COUNT:   col_setting = data[3:0];
            CFG_SINGLE_KEYS: key_setting = data[5:0];
            CFG_JITTER:      jitter_setting = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        samp_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [LINE_W-1:0] lv, input logic typed,
                               input t_result want);
        int i;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct()) begin
            samp_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        samp_if.valid <= 1'b1;
        samp_if.line_levels <= lv;
        do @(posedge i_clk); while (!samp_if.ready);
        scan_predict(lv);
        if (typed) begin
            expected_q.push_back(want);
        end else begin
            for (i = 0; i < step_n; i++) expected_q.push_back(step_res[i]);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            evt_if.ready <= 1'b0;
        end else if (hold_done != hold_reqs) begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            evt_if.ready <= 1'b0;
        end else begin
            evt_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct());
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            got = {evt_if.event_valid, evt_if.key_number, evt_if.is_press,
                   evt_if.row_drive, evt_if.last_result};
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected beat: ev=%0d key=%0d press=%0d drive=%h last=%0d",
                             got.event_valid, got.key_number, got.is_press,
                             got.row_drive, got.last_result);
                end
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch: expected ev=%0d key=%0d press=%0d drive=%h last=%0d",
                                 want.event_valid, want.key_number, want.is_press,
                                 want.row_drive, want.last_result);
                        $display("          actual   ev=%0d key=%0d press=%0d drive=%h last=%0d",
                                 got.event_valid, got.key_number, got.is_press,
                                 got.row_drive, got.last_result);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((samp_if.valid && samp_if.ready) || (evt_if.valid && evt_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int k;
        t_scan_row row;
        logic [3:0] rows;
        logic [3:0] cols;
        logic [5:0] keys;
        logic [7:0] jit;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        samp_if.valid = 1'b0;
        samp_if.line_levels = '0;
        evt_if.ready = 1'b0;
        for (k = 0; k < KEY_SLOTS; k++) key_counts[k] = '0;
        scan_row = '0;
        single_mode = 1'b0;
        row_setting = 4'd4;
        col_setting = 4'd4;
        key_setting = 6'd8;
        jitter_setting = 8'd5;
        held_keys = '0;
        idle_mode = IDLE_NONE;
        errors = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_left = 0;
        quiet_cycles = 0;

        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b0, 6'd0, 1'b0, 8'hFD)));
        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b0, 6'd0, 1'b0, 8'hFB)));
        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b0, 6'd0, 1'b0, 8'hF7)));
        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b0, 6'd0, 1'b0, 8'hFE)));
        directed_rows.push_back(write_row(CFG_JITTER, 8'd0));
        directed_rows.push_back(typed_row(32'hFFFF_FFFE, res(1'b1, 6'd0, 1'b1, 8'hFD)));
        directed_rows.push_back(sample_row(32'h0000_0000));
        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b0, 6'd0, 1'b0, 8'hF7)));
        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b0, 6'd0, 1'b0, 8'hFE)));
        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b1, 6'd0, 1'b0, 8'hFD)));
        directed_rows.push_back(write_row(CFG_JITTER, 8'hFF));
        directed_rows.push_back(write_row(CFG_ROW_COUNT, 8'h0F));
        directed_rows.push_back(write_row(CFG_COL_COUNT, 8'h0F));
        directed_rows.push_back(sample_row(32'h0000_0000));
        directed_rows.push_back(sample_row(32'hAAAA_AAAA));
        directed_rows.push_back(sample_row(32'h5555_5555));
        directed_rows.push_back(sample_row(32'h0F0F_0F0F));
        directed_rows.push_back(write_row(CFG_ROW_COUNT, 8'h00));
        directed_rows.push_back(write_row(CFG_COL_COUNT, 8'h00));
        directed_rows.push_back(typed_row(32'hFFFF_FFFE, res(1'b0, 6'd0, 1'b0, 8'hFE)));
        directed_rows.push_back(write_row(CFG_SCAN_MODE, 8'h01));
        directed_rows.push_back(write_row(CFG_SINGLE_KEYS, 8'h3F));
        directed_rows.push_back(write_row(CFG_JITTER, 8'd0));
        directed_rows.push_back(sample_row(32'hFFFF_FFFF));
        directed_rows.push_back(sample_row(32'h0000_0000));
        directed_rows.push_back(sample_row(32'h8000_0001));
        directed_rows.push_back(write_row(CFG_SINGLE_KEYS, 8'h00));
        directed_rows.push_back(write_row(CFG_JITTER, 8'd1));
        directed_rows.push_back(typed_row(32'hFFFF_FFFF, res(1'b0, 6'd0, 1'b0, NO_DRIVE)));
        directed_rows.push_back(typed_row(32'hFFFF_FFFE, res(1'b1, 6'd0, 1'b0, NO_DRIVE)));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_sample(row.levels, row.typed, row.want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            settle();
            idle_mode = t_idle_mode'(p % 4);
            rows = 4'($urandom_range(0, 15));
            cols = 4'($urandom_range(0, 15));
            keys = 6'($urandom_range(0, 63));
            jit = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(250, 255)
                                                  : $urandom_range(0, 3));
            if (p == 0) begin
                rows = 4'd4;
                cols = 4'd4;
            end
            if (p == 1) keys = 6'd32;
            if (p == 2) begin
                rows = 4'd8;
                cols = 4'd8;
            end
            write_reg(CFG_SCAN_MODE, CFG_DAT_W'(p % 2));
            write_reg(CFG_ROW_COUNT, {4'd0, rows});
            write_reg(CFG_COL_COUNT, {4'd0, cols});
            write_reg(CFG_SINGLE_KEYS, {2'd0, keys});
            write_reg(CFG_JITTER, jit);
            for (k = 0; k < PHASE_BEATS; k++) begin
                if (p == 5 && k == 10) hold_reqs++;
                if (p == 6 && k == 16) settle();
                send_sample(next_levels(), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: keypad_scan_debounce.f
rtl/kpsd_pkg.sv
rtl/kpsd_in_if.sv
rtl/kpsd_out_if.sv
rtl/kpsd_ctrl.sv
rtl/kpsd_datapath.sv
rtl/keypad_scan_debounce.sv
test/tb_top.sv
